// ===== rtl/prs_pkg.sv =====
// shared types, codes and reset values for the power triggered relay sequencer
package prs_pkg;

  // controller modes, numbered as they appear on next_mode
  typedef enum logic [2:0] {
    MODE_MAN_IDLE  = 3'd0,
    MODE_MAN_RUN   = 3'd1,
    MODE_AUTO_IDLE = 3'd2,
    MODE_AUTO_RUN  = 3'd3,
    MODE_FORCE_ON  = 3'd4,
    MODE_FORCE_OFF = 3'd5,
    MODE_COOL      = 3'd6
  } mode_t;

  // power lamp codes
  localparam logic [1:0] PWR_LAMP_OFF   = 2'd0;
  localparam logic [1:0] PWR_LAMP_ARMED = 2'd1;
  localparam logic [1:0] PWR_LAMP_RUN   = 2'd2;

  // button lamp codes
  localparam logic [1:0] BTN_LAMP_OFF       = 2'd0;
  localparam logic [1:0] BTN_LAMP_FORCE_OFF = 2'd1;
  localparam logic [1:0] BTN_LAMP_FORCE_ON  = 2'd2;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_TRIG_WATTS  = 2'd0,
    REG_VAC_DRAW    = 2'd1,
    REG_COOLDOWN_MS = 2'd2
  } reg_idx_t;

  localparam int unsigned CFG_ADDR_W = 4;

  // configuration reset values
  localparam logic [13:0] TRIG_WATTS_RST  = 14'd500;
  localparam logic [13:0] VAC_DRAW_RST    = 14'd1500;
  localparam logic [31:0] COOLDOWN_MS_RST = 32'd5000;

  typedef struct packed {
    logic [31:0] cooldown_ms;
    logic [13:0] vac_draw;
    logic [13:0] trig_watts;
  } cfg_t;

  // one control tick
  typedef struct packed {
    logic [31:0] now_ms;
    logic [14:0] avg_watts;
    logic        override_press;
    logic        armed;
  } item_t;

  // one result
  typedef struct packed {
    mode_t       next_mode;
    logic [1:0]  button_led_code;
    logic [1:0]  power_led_code;
    logic        relay_on;
  } result_t;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 8;

endpackage

// ===== rtl/prs_cfg.sv =====
// apb configuration registers for the relay sequencer
module prs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [prs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  output prs_pkg::cfg_t                    cfg
);
  import prs_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register write decode, unmapped addresses are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TRIG_WATTS:  cfg_nxt.trig_watts  = cfg_pwdata[13:0];
        REG_VAC_DRAW:    cfg_nxt.vac_draw    = cfg_pwdata[13:0];
        REG_COOLDOWN_MS: cfg_nxt.cooldown_ms = cfg_pwdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // readback mux
  always_comb begin
    case (idx)
      REG_TRIG_WATTS:  cfg_prdata = {18'd0, cfg_r.trig_watts};
      REG_VAC_DRAW:    cfg_prdata = {18'd0, cfg_r.vac_draw};
      REG_COOLDOWN_MS: cfg_prdata = cfg_r.cooldown_ms;
      default:         cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_watts  <= TRIG_WATTS_RST;
      cfg_r.vac_draw    <= VAC_DRAW_RST;
      cfg_r.cooldown_ms <= COOLDOWN_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/prs_ctrl.sv =====
// seven-mode controller: entry actions, transitions and controller state
module prs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  prs_pkg::item_t    item,
  input  prs_pkg::cfg_t     cfg,
  output prs_pkg::result_t  res
);
  import prs_pkg::*;

  mode_t       mode_r,        mode_nxt;
  logic        entry_done_r,  entry_done_nxt;
  logic [31:0] run_time_r,    run_time_nxt;
  logic [31:0] cool_time_r,   cool_time_nxt;
  logic        dropped_r,     dropped_nxt;
  logic        relay_r,       relay_nxt;
  logic [1:0]  pwr_lamp_r,    pwr_lamp_nxt;
  logic [1:0]  btn_lamp_r,    btn_lamp_nxt;

  logic [14:0] run_limit;
  logic [14:0] min_ext;
  logic [31:0] run_elapsed;
  logic [31:0] cool_elapsed;
  logic        low_run;
  logic        above_min;

  // threshold sum never overflows at 15 bits
  assign min_ext   = {1'b0, cfg.trig_watts};
  assign run_limit = min_ext + {1'b0, cfg.vac_draw};
  assign low_run   = item.avg_watts <= run_limit;
  assign above_min = item.avg_watts > min_ext;

  // entry actions on the first tick in a mode
  always_comb begin
    relay_nxt     = relay_r;
    pwr_lamp_nxt  = pwr_lamp_r;
    btn_lamp_nxt  = btn_lamp_r;
    run_time_nxt  = run_time_r;
    cool_time_nxt = cool_time_r;
    dropped_nxt   = dropped_r;
    if (!entry_done_r) begin
      case (mode_r)
        MODE_MAN_RUN: begin
          relay_nxt    = 1'b1;
          pwr_lamp_nxt = PWR_LAMP_RUN;
        end
        MODE_AUTO_IDLE: begin
          relay_nxt    = 1'b0;
          pwr_lamp_nxt = PWR_LAMP_ARMED;
          btn_lamp_nxt = BTN_LAMP_OFF;
        end
        MODE_AUTO_RUN: begin
          relay_nxt    = 1'b1;
          pwr_lamp_nxt = PWR_LAMP_RUN;
          run_time_nxt = item.now_ms;
        end
        MODE_FORCE_ON: begin
          relay_nxt    = 1'b1;
          pwr_lamp_nxt = PWR_LAMP_RUN;
          btn_lamp_nxt = BTN_LAMP_FORCE_ON;
        end
        MODE_FORCE_OFF: begin
          relay_nxt    = 1'b0;
          pwr_lamp_nxt = PWR_LAMP_ARMED;
          btn_lamp_nxt = BTN_LAMP_FORCE_OFF;
        end
        MODE_COOL: begin
          relay_nxt     = 1'b0;
          pwr_lamp_nxt  = PWR_LAMP_ARMED;
          btn_lamp_nxt  = BTN_LAMP_OFF;
          cool_time_nxt = item.now_ms;
          dropped_nxt   = 1'b0;
        end
        default: begin
          relay_nxt    = 1'b0;
          pwr_lamp_nxt = PWR_LAMP_OFF;
        end
      endcase
    end

    // the power-drop flag can be set in the same tick as entry clears it
    if (mode_r == MODE_COOL && item.armed && !above_min) begin
      dropped_nxt = 1'b1;
    end
  end

  // elapsed times wrap modulo 2^32
  assign run_elapsed  = item.now_ms - run_time_nxt;
  assign cool_elapsed = item.now_ms - cool_time_nxt;

  // mode transitions
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_MAN_RUN: begin
        if (item.armed)               mode_nxt = MODE_AUTO_IDLE;
        else if (item.override_press) mode_nxt = MODE_MAN_IDLE;
      end
      MODE_AUTO_IDLE: begin
        if (!item.armed)              mode_nxt = MODE_MAN_IDLE;
        else if (item.override_press) mode_nxt = MODE_FORCE_ON;
        else if (above_min)           mode_nxt = MODE_AUTO_RUN;
      end
      MODE_AUTO_RUN: begin
        if (!item.armed)              mode_nxt = MODE_MAN_IDLE;
        else if (item.override_press) mode_nxt = MODE_FORCE_OFF;
        else if (run_elapsed > cfg.cooldown_ms && low_run) mode_nxt = MODE_COOL;
      end
      MODE_FORCE_ON: begin
        if (!item.armed)              mode_nxt = MODE_MAN_IDLE;
        else if (item.override_press) mode_nxt = MODE_COOL;
      end
      MODE_FORCE_OFF: begin
        if (!item.armed || item.override_press || low_run) mode_nxt = MODE_MAN_IDLE;
      end
      MODE_COOL: begin
        if (!item.armed) mode_nxt = MODE_MAN_IDLE;
        else if (dropped_nxt && cool_elapsed > cfg.cooldown_ms) mode_nxt = MODE_AUTO_IDLE;
      end
      MODE_MAN_IDLE: begin
        if (item.armed)               mode_nxt = MODE_AUTO_IDLE;
        else if (item.override_press) mode_nxt = MODE_MAN_RUN;
      end
      default: begin
        // unreachable code, treated as manual idle
        if (item.armed)               mode_nxt = MODE_AUTO_IDLE;
        else if (item.override_press) mode_nxt = MODE_MAN_RUN;
        else                          mode_nxt = MODE_MAN_IDLE;
      end
    endcase
    entry_done_nxt = (mode_nxt == mode_r);
  end

  // result of this tick
  assign res.relay_on        = relay_nxt;
  assign res.power_led_code  = pwr_lamp_nxt;
  assign res.button_led_code = btn_lamp_nxt;
  assign res.next_mode       = mode_nxt;

  // controller state, advanced once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_MAN_IDLE;
      entry_done_r <= 1'b0;
      run_time_r   <= 32'd0;
      cool_time_r  <= 32'd0;
      dropped_r    <= 1'b0;
      relay_r      <= 1'b0;
      pwr_lamp_r   <= PWR_LAMP_OFF;
      btn_lamp_r   <= BTN_LAMP_OFF;
    end else if (step_en) begin
      mode_r       <= mode_nxt;
      entry_done_r <= entry_done_nxt;
      run_time_r   <= run_time_nxt;
      cool_time_r  <= cool_time_nxt;
      dropped_r    <= dropped_nxt;
      relay_r      <= relay_nxt;
      pwr_lamp_r   <= pwr_lamp_nxt;
      btn_lamp_r   <= btn_lamp_nxt;
    end
  end

endmodule

// ===== rtl/power_triggered_relay_sequencer_top.sv =====
// top level of the power triggered relay sequencer: stream ports, apb port, pipeline
// a request passes the input register and then the result register before it shows on out_*
// one request per clock unless the output stalls; mode state updates in one pass each tick
// the input register and the result register both accept while their content moves on
// reset (synchronous, rst_n low): both registers empty, manual idle mode, relay and lamps off
// configuration returns to trigger threshold 500, vacuum draw 1500, cooldown_ms 5000
module power_triggered_relay_sequencer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: armed[0], override_press[1], avg_watts[16:2], now_ms[48:17], ignored[55:49]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [prs_pkg::IN_DATA_W-1:0]       in_tdata,
  // out_tdata: relay_on[0], power_led_code[2:1], button_led_code[4:3], next_mode[7:5]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [prs_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [prs_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import prs_pkg::*;

  cfg_t    cfg;
  item_t   in_item_r;
  logic    in_valid_r;
  result_t res;
  result_t out_res_r;
  logic    out_valid_r;
  logic    out_free;
  logic    step_en;

  prs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // handshake: the result slot frees when empty or taken this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || step_en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= item_t'(in_tdata[$bits(item_t)-1:0]);
    end
  end

  prs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

  // a relay that is on always shows the running power lamp
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.relay_on == (out_res_r.power_led_code == PWR_LAMP_RUN)))
    else $error("relay and power lamp disagree");

  // a held input request stays until the controller takes it
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !step_en) |=> in_valid_r)
    else $error("input request lost while stalled");

  // a stalled result register keeps its content
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("pending result changed under stall");

  // reset empties the result register
  assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule
